// ----- src/srlcc_pkg.sv -----
// Shared types and constants of the S-record line checksum checker.
`default_nettype none

package srlcc_pkg;

    // Character classes produced by the front classifier
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CHAR    = 2'd0;
    localparam t_kind KIND_NEWLINE = 2'd1;
    localparam t_kind KIND_END     = 2'd2;

    // Line status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_VALID     = 2'd0;
    localparam t_status ST_MISMATCH  = 2'd1;
    localparam t_status ST_BAD_START = 2'd2;
    localparam t_status ST_MALFORMED = 2'd3;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_S       = 8'd83;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_F = 8'd70;
    localparam logic [7:0] HEX_A_OFFSET = 8'd55;  // 'A' - 10

    // One classified input beat
    typedef struct packed {
        t_kind      kind;
        logic       is_s;
        logic       hex_ok;
        logic [3:0] nibble;
    } t_cls;

    // One line result
    typedef struct packed {
        t_status    status;
        logic [7:0] stored;
        logic [7:0] computed;
        logic       final_line;
    } t_res;

    localparam int CLS_W = $bits(t_cls);
    localparam int RES_W = $bits(t_res);

endpackage

`default_nettype wire

// ----- src/srlcc_fifo.sv -----
// Small register queue used between the checker stages and on the result side.
`default_nettype none

module srlcc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2   // power of two
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- src/srlcc_front.sv -----
// Front classifier: turns a raw character beat into a classified beat.
`default_nettype none

module srlcc_front (
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_stream_end,
    output srlcc_pkg::t_cls o_cls
);

    logic       is_digit, is_upper_hex;
    logic [7:0] digit_val, upper_val;

    assign is_digit     = (i_char_code >= srlcc_pkg::CH_ZERO) &&
                          (i_char_code <= srlcc_pkg::CH_NINE);
    assign is_upper_hex = (i_char_code >= srlcc_pkg::CH_UPPER_A) &&
                          (i_char_code <= srlcc_pkg::CH_UPPER_F);
    assign digit_val    = i_char_code - srlcc_pkg::CH_ZERO;
    assign upper_val    = i_char_code - srlcc_pkg::HEX_A_OFFSET;

    always_comb begin
        if (i_stream_end) begin
            o_cls.kind = srlcc_pkg::KIND_END;
        end else if (i_char_code == srlcc_pkg::CH_NEWLINE) begin
            o_cls.kind = srlcc_pkg::KIND_NEWLINE;
        end else begin
            o_cls.kind = srlcc_pkg::KIND_CHAR;
        end
        o_cls.is_s   = (i_char_code == srlcc_pkg::CH_S);
        o_cls.hex_ok = is_digit || is_upper_hex;
        if (is_digit) begin
            o_cls.nibble = digit_val[3:0];
        end else if (is_upper_hex) begin
            o_cls.nibble = upper_val[3:0];
        end else begin
            o_cls.nibble = 4'd0;
        end
    end

endmodule

`default_nettype wire

// ----- src/srlcc_back.sv -----
// Back end: line state, pair summing and status for each closed line.
`default_nettype none

module srlcc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire srlcc_pkg::t_cls  i_cls,
    output logic                  o_take,
    output logic                  o_res_push,
    output srlcc_pkg::t_res       o_res,
    input  wire logic             i_res_full
);

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_high, n_high;
    logic       r_half, n_half;
    logic       r_pair_bad, n_pair_bad;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_last, n_last;
    logic [1:0] r_seen, n_seen;
    logic       r_bad_start, n_bad_start;

    logic       closes;
    logic [7:0] pair_byte;

    // A beat closes a line on newline, or on stream end within a line
    assign closes = (i_cls.kind == srlcc_pkg::KIND_NEWLINE) ||
                    ((i_cls.kind == srlcc_pkg::KIND_END) && (r_phase != PH_START));
    assign o_take     = i_valid && (!closes || !i_res_full);
    assign o_res_push = o_take && closes;
    assign pair_byte  = (r_pair_bad || !i_cls.hex_ok) ? 8'd0 : {r_high, i_cls.nibble};

    // Status of the line as it stands
    always_comb begin
        o_res.stored     = 8'd0;
        o_res.computed   = 8'd0;
        o_res.final_line = (i_cls.kind == srlcc_pkg::KIND_END);
        if (r_bad_start || r_phase == PH_START) begin
            o_res.status = srlcc_pkg::ST_BAD_START;
        end else if (r_phase == PH_TYPE || r_half || r_seen < 2'd2) begin
            o_res.status = srlcc_pkg::ST_MALFORMED;
        end else begin
            o_res.stored   = r_last;
            o_res.computed = ~r_sum;
            o_res.status   = (r_last == ~r_sum) ? srlcc_pkg::ST_VALID
                                                : srlcc_pkg::ST_MISMATCH;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_high      = r_high;
        n_half      = r_half;
        n_pair_bad  = r_pair_bad;
        n_sum       = r_sum;
        n_last      = r_last;
        n_seen      = r_seen;
        n_bad_start = r_bad_start;
        if (o_take) begin
            if (i_cls.kind != srlcc_pkg::KIND_CHAR) begin
                // close or drop the line: start afresh
                n_phase     = PH_START;
                n_high      = 4'd0;
                n_half      = 1'b0;
                n_pair_bad  = 1'b0;
                n_sum       = 8'd0;
                n_last      = 8'd0;
                n_seen      = 2'd0;
                n_bad_start = 1'b0;
            end else begin
                case (r_phase)
                    PH_START: begin
                        n_bad_start = !i_cls.is_s;
                        n_phase     = i_cls.is_s ? PH_TYPE : PH_BODY;
                    end
                    PH_TYPE: begin
                        n_phase = PH_BODY;
                    end
                    default: begin
                        if (!r_bad_start) begin
                            if (!r_half) begin
                                n_high     = i_cls.nibble;
                                n_pair_bad = !i_cls.hex_ok;
                                n_half     = 1'b1;
                            end else begin
                                if (r_seen != 2'd0) begin
                                    n_sum = r_sum + r_last;
                                end
                                n_last     = pair_byte;
                                n_seen     = (r_seen == 2'd2) ? 2'd2 : r_seen + 1'b1;
                                n_half     = 1'b0;
                                n_pair_bad = 1'b0;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_high      <= 4'd0;
            r_half      <= 1'b0;
            r_pair_bad  <= 1'b0;
            r_sum       <= 8'd0;
            r_last      <= 8'd0;
            r_seen      <= 2'd0;
            r_bad_start <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_high      <= n_high;
            r_half      <= n_half;
            r_pair_bad  <= n_pair_bad;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_bad_start <= n_bad_start;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_valid_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && (o_res.status == srlcc_pkg::ST_VALID)
            |-> (o_res.stored == o_res.computed))
        else $error("valid status without matching checksum");

    a_fault_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push && (o_res.status == srlcc_pkg::ST_BAD_START ||
                       o_res.status == srlcc_pkg::ST_MALFORMED)
            |-> (o_res.stored == 8'd0 && o_res.computed == 8'd0))
        else $error("checksums not cleared on a faulty line");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && (i_cls.kind == srlcc_pkg::KIND_END) |=> (r_phase == PH_START))
        else $error("stream end did not return to line start");

endmodule

`default_nettype wire

// ----- src/srecord_line_checksum_checker.sv -----
// Top level of the S-record line checksum checker.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  input     | push / full          | i_char_code[7:0], i_stream_end
//  result    | pop / empty          | o_line_status[1:0], o_stored_checksum[7:0],
//            |                      | o_computed_checksum[7:0], o_final_line
//
// One character beat per cycle is sustained while no closing beat waits on a full
// result queue: the back end updates the line state with at most one 8-bit add per beat.
// A closing beat is registered in the character queue, and its status is registered in
// the result queue when the back end takes that beat.
// Reset is synchronous, active low, and empties both queues and clears the line.
// A full result queue stalls the back end only while the head beat closes a line;
// beats behind it wait, and input stalls via full once the character queue fills.
`default_nettype none

module srecord_line_checksum_checker #(
    parameter int CHAR_QUEUE_DEPTH = 2,
    parameter int RES_QUEUE_DEPTH  = 2
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_stream_end,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      o_line_status,
    output logic [7:0]      o_stored_checksum,
    output logic [7:0]      o_computed_checksum,
    output logic            o_final_line
);

    srlcc_pkg::t_cls front_cls;
    srlcc_pkg::t_cls queued_cls;
    srlcc_pkg::t_res back_res;
    srlcc_pkg::t_res head_res;

    logic [srlcc_pkg::CLS_W-1:0] queued_bits;
    logic [srlcc_pkg::RES_W-1:0] head_bits;
    logic                        char_empty;
    logic                        back_take;
    logic                        res_push;
    logic                        res_full;

    // Classify each raw character beat
    srlcc_front u_front (
        .i_char_code  (i_char_code),
        .i_stream_end (i_stream_end),
        .o_cls        (front_cls)
    );

    // Decouple the classifier from the line state
    srlcc_fifo #(
        .WIDTH (srlcc_pkg::CLS_W),
        .DEPTH (CHAR_QUEUE_DEPTH)
    ) u_char_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cls),
        .o_full  (full),
        .i_pop   (back_take),
        .o_data  (queued_bits),
        .o_empty (char_empty)
    );

    assign queued_cls = srlcc_pkg::t_cls'(queued_bits);

    // Advance the line state and raise a status on each line close
    srlcc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!char_empty),
        .i_cls      (queued_cls),
        .o_take     (back_take),
        .o_res_push (res_push),
        .o_res      (back_res),
        .i_res_full (res_full)
    );

    // Hold statuses until the consumer pops them
    srlcc_fifo #(
        .WIDTH (srlcc_pkg::RES_W),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty)
    );

    assign head_res            = srlcc_pkg::t_res'(head_bits);
    assign o_line_status       = head_res.status;
    assign o_stored_checksum   = head_res.stored;
    assign o_computed_checksum = head_res.computed;
    assign o_final_line        = head_res.final_line;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the S-record line checksum checker.
module tb_top;

    // Stall limit: cycles in a row with no beat accepted on either side
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        LINE_START,
        LINE_TYPE,
        LINE_BODY
    } t_line_phase;

    // Tracks one S-record line at a time and holds the statuses still owed by the block
    class srec_line_tracker;
        t_line_phase     phase;
        logic [3:0]      hi_digit;
        logic            half_open;
        logic            pair_bad;
        logic            not_s;
        logic [7:0]      sum_before;
        logic [7:0]      latest_pair;
        logic [1:0]      pairs_seen;
        srlcc_pkg::t_res due_status[$];
        int              mismatches;

        function new();
            restart_line();
            mismatches = 0;
        endfunction

        function void restart_line();
            phase       = LINE_START;
            hi_digit    = '0;
            half_open   = 1'b0;
            pair_bad    = 1'b0;
            not_s       = 1'b0;
            sum_before  = '0;
            latest_pair = '0;
            pairs_seen  = '0;
        endfunction

        function void close_record(logic ending);
            srlcc_pkg::t_res r;
            r.stored     = '0;
            r.computed   = '0;
            r.final_line = ending;
            if (not_s || phase == LINE_START) begin
                r.status = srlcc_pkg::ST_BAD_START;
            end else if (phase == LINE_TYPE || half_open || pairs_seen < 2) begin
                r.status = srlcc_pkg::ST_MALFORMED;
            end else begin
                r.stored   = latest_pair;
                r.computed = ~sum_before;
                r.status   = (r.stored == r.computed) ? srlcc_pkg::ST_VALID
                                                      : srlcc_pkg::ST_MISMATCH;
            end
            due_status.push_back(r);
            restart_line();
        endfunction

        // Note one accepted input beat
        function void take_char(logic [7:0] c, logic ending);
            logic       is_hex;
            logic [7:0] offs;
            logic [7:0] pair;
            if (ending) begin
                // end of stream on a fresh line closes nothing
                if (phase != LINE_START)
                    close_record(1'b1);
                return;
            end
            if (c == srlcc_pkg::CH_NEWLINE) begin
                close_record(1'b0);
                return;
            end
            case (phase)
                LINE_START: begin
                    not_s = (c != srlcc_pkg::CH_S);
                    phase = not_s ? LINE_BODY : LINE_TYPE;
                end
                LINE_TYPE: phase = LINE_BODY;
                default: begin
                    if (!not_s) begin
                        offs = '0;
                        is_hex = 1'b0;
                        if (c >= srlcc_pkg::CH_ZERO && c <= srlcc_pkg::CH_NINE) begin
                            offs   = c - srlcc_pkg::CH_ZERO;
                            is_hex = 1'b1;
                        end else if (c >= srlcc_pkg::CH_UPPER_A &&
                                     c <= srlcc_pkg::CH_UPPER_F) begin
                            offs   = c - srlcc_pkg::HEX_A_OFFSET;
                            is_hex = 1'b1;
                        end
                        if (!half_open) begin
                            hi_digit  = offs[3:0];
                            pair_bad  = !is_hex;
                            half_open = 1'b1;
                        end else begin
                            pair = (pair_bad || !is_hex) ? 8'h00 : {hi_digit, offs[3:0]};
                            if (pairs_seen != 0)
                                sum_before = sum_before + latest_pair;
                            latest_pair = pair;
                            if (pairs_seen < 2)
                                pairs_seen++;
                            half_open = 1'b0;
                            pair_bad  = 1'b0;
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one popped status beat with the oldest one owed
        task match_status(srlcc_pkg::t_res got);
            srlcc_pkg::t_res want;
            if (due_status.size() == 0) begin
                report($sformatf("status %0d popped with nothing due", got.status));
                return;
            end
            want = due_status.pop_front();
            if (got.status !== want.status)
                report($sformatf("line_status %0d, want %0d", got.status, want.status));
            if (got.stored !== want.stored)
                report($sformatf("stored_checksum %02h, want %02h", got.stored, want.stored));
            if (got.computed !== want.computed)
                report($sformatf("computed_checksum %02h, want %02h",
                                 got.computed, want.computed));
            if (got.final_line !== want.final_line)
                report($sformatf("final_line %0b, want %0b", got.final_line, want.final_line));
        endtask

        function int pending();
            return due_status.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_char_code;
    logic       i_stream_end;
    logic       empty;
    logic       pop;
    logic [1:0] o_line_status;
    logic [7:0] o_stored_checksum;
    logic [7:0] o_computed_checksum;
    logic       o_final_line;

    srec_line_tracker tracker = new();

    logic [8:0] line_beats[$];   // {stream_end, char} beats of the line being built
    int         chars_sent  = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;

    srecord_line_checksum_checker u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_char_code         (i_char_code),
        .i_stream_end        (i_stream_end),
        .empty               (empty),
        .pop                 (pop),
        .o_line_status       (o_line_status),
        .o_stored_checksum   (o_stored_checksum),
        .o_computed_checksum (o_computed_checksum),
        .o_final_line        (o_final_line)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample both handshakes at the rising edge; inputs only move on the falling edge
    always @(posedge i_clk) begin : monitor
        srlcc_pkg::t_res seen;
        logic            moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                tracker.take_char(i_char_code, i_stream_end);
                moved = 1'b1;
            end
            if (pop && !empty) begin
                seen.status     = o_line_status;
                seen.stored     = o_stored_checksum;
                seen.computed   = o_computed_checksum;
                seen.final_line = o_final_line;
                tracker.match_status(seen);
                moved = 1'b1;
            end
        end
        idle_cycles <= (moved || !i_rst_n) ? 0 : idle_cycles + 1;
    end

    // Watchdog: give up once nothing has moved for too long
    initial begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("srecord_line_checksum_checker regression: fail");
        $finish;
    end

    // Receiver: alternate between free flow, sparse stalls, hard stalls and coin flips
    initial begin
        int mode;
        pop = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 30)) begin
                @(negedge i_clk);
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= ($urandom_range(0, 3) != 0);
                    2:       pop <= 1'b0;
                    default: pop <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n);
        return (n < 4'd10) ? srlcc_pkg::CH_ZERO + n : srlcc_pkg::CH_UPPER_A + (n - 4'd10);
    endfunction

    // Any character that is neither a hex digit nor a newline, boundaries favoured
    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0: c = 8'($urandom_range(97, 102));    // lower-case hex letters are not digits
            1: begin
                case ($urandom_range(0, 3))
                    0:       c = srlcc_pkg::CH_ZERO - 8'd1;
                    1:       c = srlcc_pkg::CH_NINE + 8'd1;
                    2:       c = srlcc_pkg::CH_UPPER_A - 8'd1;
                    default: c = srlcc_pkg::CH_UPPER_F + 8'd1;
                endcase
            end
            default: begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == srlcc_pkg::CH_NEWLINE ||
                       (c >= srlcc_pkg::CH_ZERO && c <= srlcc_pkg::CH_NINE) ||
                       (c >= srlcc_pkg::CH_UPPER_A && c <= srlcc_pkg::CH_UPPER_F));
            end
        endcase
        return c;
    endfunction

    task automatic push_char(logic [7:0] c);
        line_beats.push_back({1'b0, c});
    endtask

    // End of stream; the character field is don't-care, so drive noise on it
    task automatic push_end();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        line_beats.push_back({1'b1, junk});
    endtask

    task automatic push_pair(logic [7:0] b);
        push_char(hex_char(b[7:4]));
        push_char(hex_char(b[3:0]));
    endtask

    task automatic type_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    // Drive one beat, holding it until accepted; open a random gap between bursts
    task automatic send_beat(logic [7:0] c, logic ending);
        if (burst_left == 0) begin
            repeat (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16)) begin
                @(negedge i_clk);
                push <= 1'b0;
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        @(negedge i_clk);
        push         <= 1'b1;
        i_char_code  <= c;
        i_stream_end <= ending;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic flush_line();
        foreach (line_beats[i])
            send_beat(line_beats[i][7:0], line_beats[i][8]);
        line_beats.delete();
    endtask

    // Build one random line: mostly real records, the rest broken lines and noise
    task automatic build_random_line();
        int         pick;
        int         n;
        int         idx;
        logic [7:0] total;
        logic [7:0] c;
        pick  = $urandom_range(0, 99);
        total = '0;
        if (pick < 65) begin
            push_char(srlcc_pkg::CH_S);
            push_char(8'(srlcc_pkg::CH_ZERO + $urandom_range(0, 9)));
            n = $urandom_range(1, 8);
            repeat (n) begin
                c = 8'($urandom_range(0, 255));
                push_pair(c);
                total = total + c;
            end
            c = ~total;
            // corrupt the checksum now and then
            if ($urandom_range(0, 9) == 0)
                c = c ^ (8'd1 << $urandom_range(0, 7));
            push_pair(c);
            // drop a non-digit into a digit position
            if ($urandom_range(0, 9) == 0) begin
                idx = $urandom_range(2, line_beats.size() - 1);
                line_beats[idx] = {1'b0, non_hex_char()};
            end
            // carriage return is just one more digit position
            if ($urandom_range(0, 11) == 0)
                push_char(8'd13);
        end else if (pick < 75) begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == srlcc_pkg::CH_S || c == srlcc_pkg::CH_NEWLINE);
            push_char(c);
            repeat ($urandom_range(0, 12)) begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == srlcc_pkg::CH_NEWLINE);
                push_char(c);
            end
        end else if (pick < 85) begin
            // short bodies: too few pairs, odd digit counts, stray non-digits
            push_char(srlcc_pkg::CH_S);
            push_char($urandom_range(0, 255) == srlcc_pkg::CH_NEWLINE ? srlcc_pkg::CH_S
                                                                      : srlcc_pkg::CH_ZERO);
            repeat ($urandom_range(0, 7))
                push_char(($urandom_range(0, 5) == 0) ? non_hex_char()
                                                       : hex_char(4'($urandom_range(0, 15))));
        end else if (pick < 90) begin
            // empty line, or a type that never arrives
            if ($urandom_range(0, 1) == 0)
                push_char(srlcc_pkg::CH_S);
        end else begin
            repeat ($urandom_range(1, 16))
                push_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            push_end();
        else
            push_char(srlcc_pkg::CH_NEWLINE);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_char_code  = '0;
        i_stream_end = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty line, end of stream on a fresh line, missing type,
        // bad first character, too few pairs with a carriage return,
        // a valid record and a mismatch closed by end of stream
        type_text("\n");
        push_end();
        type_text("S\n");
        push_char(8'hFF);
        type_text("\n");
        push_char(srlcc_pkg::CH_S);
        push_char(8'h00);
        type_text("AB\r\n");
        type_text("S100FF\n");
        type_text("S9F00E");
        push_end();
        flush_line();

        // Random lines until enough characters have gone through
        while (chars_sent < 400) begin
            build_random_line();
            flush_line();
        end
        @(negedge i_clk);
        push <= 1'b0;

        // Drain the owed statuses, then allow for the latency and a margin
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("srecord_line_checksum_checker regression: pass");
        else
            $display("srecord_line_checksum_checker regression: fail");
        $finish;
    end

endmodule
